FILE: rtl/c3cb_pkg.sv
// Shared types, constants and register map of the 3x3 clamped-border filter.
package c3cb_pkg;

    localparam int DEF_MAX_WIDTH  = 1024;
    localparam int DEF_MAX_HEIGHT = 4096;
    localparam int DEF_COEF_BITS  = 8;

    localparam int KROW_BITS   = 24;
    localparam int KROW_EXT    = 48;
    localparam int SCALE_BITS  = 16;
    localparam int SHIFT_BITS  = 5;
    localparam int FWIDTH_BITS = 11;
    localparam int FHEIGHT_BITS = 13;
    localparam int PIX_BITS    = 8;
    localparam int PIX_MAX     = 255;
    localparam int APB_AW      = 5;
    localparam int APB_DW      = 32;

    localparam logic [2:0] REG_KTOP   = 3'd0;
    localparam logic [2:0] REG_KMID   = 3'd1;
    localparam logic [2:0] REG_KBOT   = 3'd2;
    localparam logic [2:0] REG_SMULT  = 3'd3;
    localparam logic [2:0] REG_SSHIFT = 3'd4;
    localparam logic [2:0] REG_FWIDTH = 3'd5;
    localparam logic [2:0] REG_FHEIGHT = 3'd6;

    typedef logic [2:0][2:0][PIX_BITS-1:0] pix_win_t;

    typedef struct packed {
        logic       clear;
        logic       mac_en;
        logic [1:0] row_sel;
        logic       scale_en;
    } flt_ctrl_t;

endpackage

FILE: rtl/conv3x3_clamped_border.sv
// 3x3 weighted-sum image filter with clamped border, raster pixel stream in and out.
// A pixel transfer makes two reads of the single-read-port line store and, when a window
// result is due, three row multiply-accumulate steps, scale and clamp; handing a result
// to the output register waits for that register to free, and a drain tick skips the line
// store and only checks for and hands on a due result. Results
// leave through an output register, so the next transfer is taken while a result waits.
// Results trail the pixels by 2*width+2 frame positions; drain ticks (tuser high) flush
// the tail of a frame. A frame_width write re-derives the output row and column with a
// serial divider that holds off input until it is done. Both stores
// are plain memories with no clearing pass.
module conv3x3_clamped_border
    import c3cb_pkg::*;
#(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
    parameter int COEF_BITS  = DEF_COEF_BITS
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [7:0]        s_tdata,   // [7:0] pixel_in
    input  logic              s_tuser,   // [0] kind
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [7:0]        m_tdata,   // [7:0] pixel_out
    output logic              m_tlast,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready
);

    localparam int COLB  = $clog2(MAX_WIDTH);
    localparam int ROWB  = $clog2(MAX_HEIGHT);
    localparam int WB    = $clog2(MAX_WIDTH + 1);
    localparam int HB    = $clog2(MAX_HEIGHT + 1);
    localparam int DEPTH = 3 * MAX_WIDTH;
    localparam int AB    = $clog2(DEPTH);
    localparam int TB    = $clog2(MAX_WIDTH * MAX_HEIGHT + 1);
    localparam int CB    = TB + 2;
    localparam int DB    = $clog2(TB + 1);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_RD2   = 4'd1;
    localparam logic [3:0] S_SHIFT = 4'd2;
    localparam logic [3:0] S_ROW0  = 4'd3;
    localparam logic [3:0] S_ROW1  = 4'd4;
    localparam logic [3:0] S_ROW2  = 4'd5;
    localparam logic [3:0] S_SCALE = 4'd6;
    localparam logic [3:0] S_CLAMP = 4'd7;
    localparam logic [3:0] S_OCHK  = 4'd8;
    localparam logic [3:0] S_OCAP  = 4'd9;
    localparam logic [3:0] S_WDIV  = 4'd10;

    logic [3:0] state_reg, state_next;

    logic [KROW_BITS-1:0]         ktop_reg, kmid_reg, kbot_reg;
    logic signed [SCALE_BITS-1:0] smult_reg;
    logic [SHIFT_BITS-1:0]        sshift_reg;
    logic [FWIDTH_BITS-1:0]       fwidth_reg;
    logic [FHEIGHT_BITS-1:0]      fheight_reg;

    logic [WB-1:0] w_eff;
    logic [HB-1:0] h_eff;
    logic [TB-1:0] total_reg;
    logic [1:0]    h2_slot_reg;

    logic [COLB-1:0] in_col_reg;
    logic [ROWB-1:0] in_row_reg;
    logic [1:0]      in_slot_reg;
    logic [TB-1:0]   in_count;
    logic            tail_reg;

    logic [COLB-1:0] out_col_reg;
    logic [ROWB-1:0] out_row_reg;
    logic [1:0]      out_slot_reg;
    logic [TB-1:0]   out_index_reg;

    logic            wdiv_req_reg;
    logic [DB-1:0]   div_cnt_reg;
    logic [TB-1:0]   div_q_reg;
    logic [WB-1:0]   div_rem_reg;
    logic [1:0]      div_m_reg;
    logic [WB:0]     div_trial;
    logic            div_ge;

    logic [PIX_BITS-1:0] px_reg, top_reg;
    logic                filt_reg;
    logic [AB-1:0]       res_waddr_reg;
    pix_win_t            win_reg;

    logic [PIX_BITS-1:0] out_data_reg;
    logic                out_valid_reg, out_last_reg;

    logic                ln_we, ln_re, rs_we, rs_re;
    logic [AB-1:0]       ln_raddr, ln_waddr, rs_raddr;
    logic [PIX_BITS-1:0] ln_rdata, rs_rdata, flt_result;
    flt_ctrl_t           fctrl;

    logic                accept, cfg_wr, ready, last, out_free;
    logic [COLB-1:0]     c_cl;
    logic [1:0]          r_slot;

    function automatic logic [1:0] slot_inc(input logic [1:0] s);
        return (s == 2'd2) ? 2'd0 : s + 2'd1;
    endfunction

    function automatic logic [AB-1:0] slot_addr(input logic [1:0] s, input logic [COLB-1:0] c);
        logic [AB-1:0] base;
        unique case (s)
            2'd1:    base = AB'(MAX_WIDTH);
            2'd2:    base = AB'(2 * MAX_WIDTH);
            default: base = '0;
        endcase
        return base + AB'(c);
    endfunction

    // (2*m + b) mod 3
    function automatic logic [1:0] mod3_step(input logic [1:0] m, input logic b);
        logic [1:0] r;
        unique case (m)
            2'd1:    r = b ? 2'd0 : 2'd2;
            2'd2:    r = b ? 2'd2 : 2'd1;
            default: r = b ? 2'd1 : 2'd0;
        endcase
        return r;
    endfunction

    function automatic logic [1:0] mod3_of(input logic [HB-1:0] v);
        logic [1:0] m;
        m = 2'd0;
        for (int i = HB - 1; i >= 0; i--) begin
            m = mod3_step(m, v[i]);
        end
        return m;
    endfunction

    // Configuration registers
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ktop_reg    <= '0;
            kmid_reg    <= '0;
            kbot_reg    <= '0;
            smult_reg   <= SCALE_BITS'(256);
            sshift_reg  <= SHIFT_BITS'(8);
            fwidth_reg  <= FWIDTH_BITS'(640);
            fheight_reg <= FHEIGHT_BITS'(480);
        end else if (cfg_wr) begin
            unique case (paddr[4:2])
                REG_KTOP:    ktop_reg    <= pwdata[KROW_BITS-1:0];
                REG_KMID:    kmid_reg    <= pwdata[KROW_BITS-1:0];
                REG_KBOT:    kbot_reg    <= pwdata[KROW_BITS-1:0];
                REG_SMULT:   smult_reg   <= pwdata[SCALE_BITS-1:0];
                REG_SSHIFT:  sshift_reg  <= pwdata[SHIFT_BITS-1:0];
                REG_FWIDTH:  fwidth_reg  <= pwdata[FWIDTH_BITS-1:0];
                REG_FHEIGHT: fheight_reg <= pwdata[FHEIGHT_BITS-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[4:2])
            REG_KTOP:    prdata = APB_DW'(ktop_reg);
            REG_KMID:    prdata = APB_DW'(kmid_reg);
            REG_KBOT:    prdata = APB_DW'(kbot_reg);
            REG_SMULT:   prdata = APB_DW'(unsigned'(smult_reg));
            REG_SSHIFT:  prdata = APB_DW'(sshift_reg);
            REG_FWIDTH:  prdata = APB_DW'(fwidth_reg);
            REG_FHEIGHT: prdata = APB_DW'(fheight_reg);
            default:     prdata = '0;
        endcase
    end

    // Effective frame size
    always_comb begin
        if (32'(fwidth_reg) < 32'd3) begin
            w_eff = WB'(3);
        end else if (32'(fwidth_reg) > 32'(MAX_WIDTH)) begin
            w_eff = WB'(MAX_WIDTH);
        end else begin
            w_eff = WB'(fwidth_reg);
        end
        if (32'(fheight_reg) < 32'd3) begin
            h_eff = HB'(3);
        end else if (32'(fheight_reg) > 32'(MAX_HEIGHT)) begin
            h_eff = HB'(MAX_HEIGHT);
        end else begin
            h_eff = HB'(fheight_reg);
        end
    end

    always_ff @(posedge aclk) begin
        total_reg   <= TB'(w_eff * h_eff);
        h2_slot_reg <= mod3_of(h_eff - HB'(2));
    end

    // Sequencer
    assign s_tready = (state_reg == S_IDLE) && !wdiv_req_reg;
    assign accept   = s_tvalid && s_tready;
    assign out_free = !out_valid_reg || m_tready;

    assign in_count = TB'(in_row_reg) * TB'(w_eff) + TB'(in_col_reg);

    assign ready = tail_reg ||
                   (CB'(in_count) >= CB'(out_index_reg) + CB'(2 * w_eff) + CB'(3));
    assign last  = (CB'(out_index_reg) + CB'(1)) >= CB'(total_reg);

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (wdiv_req_reg) begin
                    state_next = S_WDIV;
                end else if (accept) begin
                    state_next = s_tuser ? S_OCHK : S_RD2;
                end
            end
            S_RD2:   state_next = S_SHIFT;
            S_SHIFT: state_next = filt_reg ? S_ROW0 : S_OCHK;
            S_ROW0:  state_next = S_ROW1;
            S_ROW1:  state_next = S_ROW2;
            S_ROW2:  state_next = S_SCALE;
            S_SCALE: state_next = S_CLAMP;
            S_CLAMP: state_next = S_OCHK;
            S_OCHK:  state_next = ready ? S_OCAP : S_IDLE;
            S_OCAP:  if (out_free) state_next = S_IDLE;
            S_WDIV:  if (div_cnt_reg == '0) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Width change: divide out_index by the new width to place the output position
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wdiv_req_reg <= 1'b0;
        end else if (cfg_wr && paddr[4:2] == REG_FWIDTH) begin
            wdiv_req_reg <= 1'b1;
        end else if (state_reg == S_IDLE && wdiv_req_reg) begin
            wdiv_req_reg <= 1'b0;
        end
    end

    always_comb begin
        div_trial = {div_rem_reg, div_q_reg[TB-1]};
        div_ge    = div_trial >= {1'b0, w_eff};
    end

    always_ff @(posedge aclk) begin
        if (state_reg == S_IDLE && wdiv_req_reg) begin
            div_cnt_reg <= DB'(TB);
            div_q_reg   <= out_index_reg;
            div_rem_reg <= '0;
            div_m_reg   <= 2'd0;
        end else if (state_reg == S_WDIV && div_cnt_reg != '0) begin
            div_cnt_reg <= div_cnt_reg - DB'(1);
            div_q_reg   <= {div_q_reg[TB-2:0], div_ge};
            div_rem_reg <= div_ge ? WB'(div_trial - {1'b0, w_eff}) : div_trial[WB-1:0];
            div_m_reg   <= mod3_step(div_m_reg, div_ge);
        end
    end

    // Line store: read two older rows, then write the new pixel
    assign ln_re    = accept || (state_reg == S_RD2);
    assign ln_raddr = (state_reg == S_RD2)
                      ? slot_addr(slot_inc(slot_inc(in_slot_reg)), in_col_reg)
                      : slot_addr(slot_inc(in_slot_reg), in_col_reg);
    assign ln_we    = (state_reg == S_SHIFT);
    assign ln_waddr = slot_addr(in_slot_reg, in_col_reg);

    c3cb_ram #(.WIDTH(PIX_BITS), .DEPTH(DEPTH)) u_line_ram (
        .aclk  (aclk),
        .we    (ln_we),
        .waddr (ln_waddr),
        .wdata (px_reg),
        .re    (ln_re),
        .raddr (ln_raddr),
        .rdata (ln_rdata)
    );

    always_ff @(posedge aclk) begin
        if (accept) begin
            px_reg   <= s_tdata;
            filt_reg <= (in_row_reg >= ROWB'(2)) && (in_col_reg >= COLB'(2));
        end
        if (state_reg == S_RD2) begin
            top_reg <= ln_rdata;
        end
        if (state_reg == S_SHIFT) begin
            res_waddr_reg <= slot_addr(slot_inc(slot_inc(in_slot_reg)), in_col_reg - COLB'(1));
        end
    end

    // Window shift and input position
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            win_reg     <= '0;
            in_col_reg  <= '0;
            in_row_reg  <= '0;
            in_slot_reg <= '0;
            tail_reg    <= 1'b0;
        end else begin
            if (state_reg == S_SHIFT) begin
                for (int i = 0; i < 3; i++) begin
                    win_reg[i][0] <= win_reg[i][1];
                    win_reg[i][1] <= win_reg[i][2];
                end
                win_reg[0][2] <= top_reg;
                win_reg[1][2] <= ln_rdata;
                win_reg[2][2] <= px_reg;
                if (WB'(in_col_reg) + WB'(1) >= w_eff) begin
                    in_col_reg <= '0;
                    if (HB'(in_row_reg) + HB'(1) >= h_eff) begin
                        in_row_reg  <= '0;
                        in_slot_reg <= '0;
                        tail_reg    <= 1'b1;
                    end else begin
                        in_row_reg  <= in_row_reg + ROWB'(1);
                        in_slot_reg <= slot_inc(in_slot_reg);
                    end
                end else begin
                    in_col_reg <= in_col_reg + COLB'(1);
                end
            end
            if (state_reg == S_OCAP && out_free && last) begin
                tail_reg <= 1'b0;
            end
        end
    end

    // Filter datapath
    always_comb begin
        fctrl.clear    = (state_reg == S_ROW0);
        fctrl.mac_en   = (state_reg == S_ROW1) || (state_reg == S_ROW2);
        fctrl.scale_en = (state_reg == S_SCALE);
        unique case (state_reg)
            S_ROW1:  fctrl.row_sel = 2'd1;
            S_ROW2:  fctrl.row_sel = 2'd2;
            default: fctrl.row_sel = 2'd0;
        endcase
    end

    c3cb_filter #(.COEF_BITS(COEF_BITS)) u_filter (
        .aclk        (aclk),
        .ctrl        (fctrl),
        .win         (win_reg),
        .k_top       (ktop_reg),
        .k_mid       (kmid_reg),
        .k_bot       (kbot_reg),
        .scale_mult  (smult_reg),
        .scale_shift (sshift_reg),
        .result      (flt_result)
    );

    // Result store: interior results, border outputs reuse the nearest one
    always_comb begin
        if (out_col_reg == '0) begin
            c_cl = COLB'(1);
        end else if (WB'(out_col_reg) >= w_eff - WB'(1)) begin
            c_cl = COLB'(w_eff - WB'(2));
        end else begin
            c_cl = out_col_reg;
        end
        if (out_row_reg == '0) begin
            r_slot = 2'd1;
        end else if (HB'(out_row_reg) >= h_eff - HB'(1)) begin
            r_slot = h2_slot_reg;
        end else begin
            r_slot = out_slot_reg;
        end
    end

    assign rs_we    = (state_reg == S_CLAMP);
    assign rs_re    = (state_reg == S_OCHK) && ready;
    assign rs_raddr = slot_addr(r_slot, c_cl);

    c3cb_ram #(.WIDTH(PIX_BITS), .DEPTH(DEPTH)) u_res_ram (
        .aclk  (aclk),
        .we    (rs_we),
        .waddr (res_waddr_reg),
        .wdata (flt_result),
        .re    (rs_re),
        .raddr (rs_raddr),
        .rdata (rs_rdata)
    );

    // Output position and output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_col_reg   <= '0;
            out_row_reg   <= '0;
            out_slot_reg  <= '0;
            out_index_reg <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (state_reg == S_WDIV && div_cnt_reg == '0) begin
                // rows past the counter range saturate; they clamp to the last centre row
                out_col_reg  <= div_rem_reg[COLB-1:0];
                out_row_reg  <= ((div_q_reg >> ROWB) != '0) ? '1 : div_q_reg[ROWB-1:0];
                out_slot_reg <= div_m_reg;
            end
            if (state_reg == S_OCAP && out_free) begin
                out_valid_reg <= 1'b1;
                if (last) begin
                    out_col_reg   <= '0;
                    out_row_reg   <= '0;
                    out_slot_reg  <= '0;
                    out_index_reg <= '0;
                end else begin
                    out_index_reg <= out_index_reg + TB'(1);
                    if (WB'(out_col_reg) + WB'(1) >= w_eff) begin
                        out_col_reg  <= '0;
                        if (out_row_reg != '1) begin
                            out_row_reg <= out_row_reg + ROWB'(1);
                        end
                        out_slot_reg <= slot_inc(out_slot_reg);
                    end else begin
                        out_col_reg <= out_col_reg + COLB'(1);
                    end
                end
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == S_OCAP && out_free) begin
            out_data_reg <= rs_rdata;
            out_last_reg <= last;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tlast  = out_last_reg;

`ifndef ASSERT_OFF
    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input taken while an item is in work");

    a_slot_range: assert property (@(posedge aclk) disable iff (!aresetn)
        in_slot_reg != 2'd3 && out_slot_reg != 2'd3)
        else $error("row slot out of range");

    a_load_origin: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(state_reg) == S_OCAP)
        else $error("output loaded outside result fetch");
`endif

endmodule

FILE: rtl/c3cb_ram.sv
// Generic simple dual-port RAM with registered read.
module c3cb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

FILE: rtl/c3cb_filter.sv
// Row-serial multiply-accumulate, scale multiply and output clamp.
module c3cb_filter
    import c3cb_pkg::*;
#(
    parameter int COEF_BITS = DEF_COEF_BITS
) (
    input  logic                          aclk,
    input  flt_ctrl_t                     ctrl,
    input  pix_win_t                      win,
    input  logic [KROW_BITS-1:0]          k_top,
    input  logic [KROW_BITS-1:0]          k_mid,
    input  logic [KROW_BITS-1:0]          k_bot,
    input  logic signed [SCALE_BITS-1:0]  scale_mult,
    input  logic [SHIFT_BITS-1:0]         scale_shift,
    output logic [PIX_BITS-1:0]           result
);

    localparam int ACCB = COEF_BITS + 13;
    localparam int PB   = ACCB + SCALE_BITS;

    logic [KROW_EXT-1:0]         krow;
    logic [2:0][PIX_BITS-1:0]    prow;
    logic signed [ACCB-1:0]      row_sum;
    logic signed [ACCB-1:0]      acc_reg;
    logic signed [PB-1:0]        prod_reg;
    logic signed [PB-1:0]        shifted;
    logic signed [COEF_BITS-1:0] cf;

    always_comb begin
        unique case (ctrl.row_sel)
            2'd1:    begin krow = KROW_EXT'(k_mid); prow = win[1]; end
            2'd2:    begin krow = KROW_EXT'(k_bot); prow = win[2]; end
            default: begin krow = KROW_EXT'(k_top); prow = win[0]; end
        endcase
    end

    always_comb begin
        row_sum = '0;
        cf = '0;
        for (int j = 0; j < 3; j++) begin
            cf = signed'(krow[j*COEF_BITS +: COEF_BITS]);
            row_sum = row_sum + ACCB'(cf) * ACCB'(signed'({1'b0, prow[j]}));
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.clear) begin
            acc_reg <= row_sum;
        end else if (ctrl.mac_en) begin
            acc_reg <= acc_reg + row_sum;
        end
        if (ctrl.scale_en) begin
            prod_reg <= PB'(acc_reg) * PB'(scale_mult);
        end
    end

    // negative sums clip to zero, large ones saturate
    always_comb begin
        shifted = prod_reg >>> scale_shift;
        if (prod_reg < 0) begin
            result = '0;
        end else if (shifted > PB'(PIX_MAX)) begin
            result = PIX_BITS'(PIX_MAX);
        end else begin
            result = shifted[PIX_BITS-1:0];
        end
    end

endmodule
